/* hw/rtl/wspi_pkg.sv */
// Shared types, register codes, reset values and saturating helpers for the wheel PI controller.
package wspi_pkg;

  // Fixed formats of the ports
  localparam int unsigned WHEEL_W      = 2;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned GAIN_W       = 24;
  localparam int unsigned DT_W         = 16;
  localparam int unsigned DT_FRAC_BITS = 16;
  localparam int unsigned ADDR_W       = 3;

  // Register indexes, taken from paddr[2]
  localparam logic REG_PROP_GAIN  = 1'b0;
  localparam logic REG_INTEG_GAIN = 1'b1;

  // Gain reset values: 0.04 and 10.0 in Q8.16
  localparam logic [GAIN_W-1:0] PROP_GAIN_RESET  = 24'd2621;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RESET = 24'd655360;

  typedef struct packed {
    logic [GAIN_W-1:0] prop;
    logic [GAIN_W-1:0] integ;
  } gains_t;

  // One item held in the input stage, error already formed
  typedef struct packed {
    logic [WHEEL_W-1:0]      wheel;
    logic signed [DATA_W-1:0] err;
    logic signed [DATA_W-1:0] upper;
    logic signed [DATA_W-1:0] lower;
    logic [DT_W-1:0]          dt;
  } stage_t;

  // Saturate a 64-bit signed value to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [63:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // Saturate a 33-bit signed sum to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] s);
    logic signed [DATA_W-1:0] r;
    if (s[DATA_W] != s[DATA_W-1]) begin
      r = s[DATA_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = s[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    return sat33(s);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_sub(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    return sat33(s);
  endfunction

endpackage

/* hw/rtl/wspi_regs.sv */
// APB-style configuration registers holding the proportional and integral gains.
module wspi_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wspi_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output wspi_pkg::gains_t            gains
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Write the addressed gain on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      gains.prop  <= wspi_pkg::PROP_GAIN_RESET;
      gains.integ <= wspi_pkg::INTEG_GAIN_RESET;
    end else if (wr_en) begin
      if (paddr[2] == wspi_pkg::REG_INTEG_GAIN) begin
        gains.integ <= pwdata[wspi_pkg::GAIN_W-1:0];
      end else begin
        gains.prop <= pwdata[wspi_pkg::GAIN_W-1:0];
      end
    end
  end

  // Read back the addressed gain
  always_comb begin
    if (paddr[2] == wspi_pkg::REG_INTEG_GAIN) begin
      prdata = {8'd0, gains.integ};
    end else begin
      prdata = {8'd0, gains.prop};
    end
  end

endmodule

/* hw/rtl/wspi_core.sv */
// PI datapath with the per-wheel integrator bank and its anti-windup clamp.
module wspi_core #(
  parameter int unsigned WHEEL_COUNT = 4,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               commit,
  input  wspi_pkg::stage_t                   stage,
  input  wspi_pkg::gains_t                   gains,
  output logic signed [wspi_pkg::DATA_W-1:0] torque
);

  localparam int unsigned IDX_W = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;
  localparam int unsigned PG_W  = wspi_pkg::DATA_W + wspi_pkg::GAIN_W + 1;
  localparam int unsigned DT_PW = wspi_pkg::DATA_W + wspi_pkg::DT_W + 1;

  logic signed [wspi_pkg::DATA_W-1:0] bank [WHEEL_COUNT];

  logic                               wheel_ok;
  logic [IDX_W-1:0]                   idx;
  logic signed [wspi_pkg::DATA_W-1:0] integ;
  logic signed [PG_W-1:0]             p_prod;
  logic signed [PG_W-1:0]             i_prod;
  logic signed [DT_PW-1:0]            d_prod;
  logic signed [PG_W-1:0]             p_sh;
  logic signed [PG_W-1:0]             i_sh;
  logic signed [DT_PW-1:0]            d_sh;
  logic signed [wspi_pkg::DATA_W-1:0] pterm;
  logic signed [wspi_pkg::DATA_W-1:0] iterm;
  logic signed [wspi_pkg::DATA_W-1:0] dterm;
  logic signed [wspi_pkg::DATA_W-1:0] sum;
  logic signed [wspi_pkg::DATA_W-1:0] grown;
  logic signed [wspi_pkg::DATA_W-1:0] hi;
  logic signed [wspi_pkg::DATA_W-1:0] lo;
  logic signed [wspi_pkg::DATA_W-1:0] hi_raw;
  logic signed [wspi_pkg::DATA_W-1:0] lo_raw;
  logic signed [wspi_pkg::DATA_W-1:0] integ_next;

  // Select the wheel's integrator; a wheel past the bank reads as zero
  assign wheel_ok = 32'(stage.wheel) < 32'(WHEEL_COUNT);
  assign idx      = IDX_W'(stage.wheel);
  assign integ    = wheel_ok ? bank[idx] : '0;

  // Products, floor-shifted and saturated
  assign p_prod = stage.err * $signed({1'b0, gains.prop});
  assign i_prod = integ * $signed({1'b0, gains.integ});
  assign d_prod = stage.err * $signed({1'b0, stage.dt});
  assign p_sh   = p_prod >>> FRAC_BITS;
  assign i_sh   = i_prod >>> FRAC_BITS;
  assign d_sh   = d_prod >>> wspi_pkg::DT_FRAC_BITS;
  assign pterm  = wspi_pkg::sat_wide($signed({{(64-PG_W){p_sh[PG_W-1]}}, p_sh}));
  assign iterm  = wspi_pkg::sat_wide($signed({{(64-PG_W){i_sh[PG_W-1]}}, i_sh}));
  assign dterm  = wspi_pkg::sat_wide($signed({{(64-DT_PW){d_sh[DT_PW-1]}}, d_sh}));

  // Torque: cap at the upper limit, then floor at the lower one
  assign sum = wspi_pkg::sat_add(pterm, iterm);
  always_comb begin
    torque = sum;
    if (torque > stage.upper) begin
      torque = stage.upper;
    end
    if (torque < stage.lower) begin
      torque = stage.lower;
    end
  end

  // Grow the integrator and clamp it to the headroom left by the P term
  assign grown  = wspi_pkg::sat_add(integ, dterm);
  assign hi_raw = wspi_pkg::sat_sub(stage.upper, pterm);
  assign lo_raw = wspi_pkg::sat_sub(stage.lower, pterm);
  assign hi     = hi_raw[wspi_pkg::DATA_W-1] ? '0 : hi_raw;
  assign lo     = lo_raw[wspi_pkg::DATA_W-1] ? lo_raw : '0;

  always_comb begin
    integ_next = grown;
    if (integ_next > hi) begin
      integ_next = hi;
    end
    if (integ_next < lo) begin
      integ_next = lo;
    end
  end

  // Write back the integrator as the item leaves the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < int'(WHEEL_COUNT); i++) begin
        bank[i] <= '0;
      end
    end else if (commit && wheel_ok) begin
      bank[idx] <= integ_next;
    end
  end

endmodule

/* hw/rtl/wheel_speed_pi_controller.sv */
// Each input item passes through the input stage register and then the result register.
// Throughput: one item per cycle while the output does not stall; the integrator read, update
// and write back of one wheel completes as the item moves from the input to the result register.
// Reset (rst, synchronous): both stages empty, gains to 0.04 and 10.0,
// every wheel integrator cleared to zero.
module wheel_speed_pi_controller #(
  parameter int unsigned WHEEL_COUNT = 4,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wspi_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               item_valid,
  output logic                               item_ready,
  input  logic [wspi_pkg::WHEEL_W-1:0]       wheel,
  input  logic signed [wspi_pkg::DATA_W-1:0] speed_setpoint,
  input  logic signed [wspi_pkg::DATA_W-1:0] speed_measured,
  input  logic signed [wspi_pkg::DATA_W-1:0] torque_upper,
  input  logic signed [wspi_pkg::DATA_W-1:0] torque_lower,
  input  logic [wspi_pkg::DT_W-1:0]          time_step,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic [wspi_pkg::WHEEL_W-1:0]       wheel_out,
  output logic signed [wspi_pkg::DATA_W-1:0] torque_command
);

  wspi_pkg::gains_t                   gains;
  wspi_pkg::stage_t                   stage;
  wspi_pkg::stage_t                   stage_next;
  logic                               stage_valid;
  logic                               advance;
  logic signed [wspi_pkg::DATA_W-1:0] torque;

  wspi_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gains   (gains)
  );

  // Move the stage on whenever the result register is free or being emptied
  assign advance    = stage_valid && (!result_valid || result_ready);
  assign item_ready = !stage_valid || advance;

  // Form the error on the way into the input stage
  always_comb begin
    stage_next.wheel = wheel;
    stage_next.err   = wspi_pkg::sat_sub(speed_setpoint, speed_measured);
    stage_next.upper = torque_upper;
    stage_next.lower = torque_lower;
    stage_next.dt    = time_step;
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      stage <= stage_next;
    end
  end

  wspi_core #(
    .WHEEL_COUNT (WHEEL_COUNT),
    .FRAC_BITS   (FRAC_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .commit (advance),
    .stage  (stage),
    .gains  (gains),
    .torque (torque)
  );

  // Result register; hold while the downstream side stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      wheel_out      <= stage.wheel;
      torque_command <= torque;
    end
  end

endmodule

/* hw/rtl/wspi_checker.sv */
// Port-level checks on the wheel PI controller's handshakes, bound to the top level.
module wspi_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               item_valid,
  input logic                               item_ready,
  input logic                               result_valid,
  input logic                               result_ready,
  input logic [wspi_pkg::WHEEL_W-1:0]       wheel_out,
  input logic signed [wspi_pkg::DATA_W-1:0] torque_command
);

  // Both stages come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!result_valid && item_ready))
    else $error("stages not empty after reset");

  // Every input transfer is followed by result_valid high after the input stage and result registers
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |-> ##2 result_valid)
    else $error("no result two cycles after an input transfer");

  // Input back-pressure only with a result stalled on the output
  a_ready_low_stall: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> (result_valid && !result_ready))
    else $error("input refused without an output stall");

  // A stalled result holds its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(wheel_out) && $stable(torque_command)))
    else $error("stalled result changed or dropped");

endmodule

bind wheel_speed_pi_controller wspi_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .item_valid     (item_valid),
  .item_ready     (item_ready),
  .result_valid   (result_valid),
  .result_ready   (result_ready),
  .wheel_out      (wheel_out),
  .torque_command (torque_command)
);
